### hw/rtl/tgc_pkg.sv
// Shared types, codes and reset constants for the touch gesture classifier.
package tgc_pkg;

	localparam int DEBOUNCE_W  = 16;
	localparam int THRESH_W    = 10;
	localparam int TAP_W       = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int COORD_W     = 10;
	localparam int TIME_W      = 32;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(50);
	localparam logic [THRESH_W-1:0]   THRESH_RESET   = THRESH_W'(30);
	localparam logic [TAP_W-1:0]      TAP_RESET      = TAP_W'(300);

	localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_THRESH   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_TAP      = 2'd2;

	localparam logic [1:0] OP_POLL  = 2'd0;
	localparam logic [1:0] OP_WAKE  = 2'd1;
	localparam logic [1:0] OP_SLEEP = 2'd2;

	localparam logic [2:0] G_NONE  = 3'd0;
	localparam logic [2:0] G_TAP   = 3'd1;
	localparam logic [2:0] G_HOLD  = 3'd2;
	localparam logic [2:0] G_LEFT  = 3'd3;
	localparam logic [2:0] G_RIGHT = 3'd4;
	localparam logic [2:0] G_UP    = 3'd5;
	localparam logic [2:0] G_DOWN  = 3'd6;
	localparam logic [2:0] G_UNUSED = 3'd7;

	typedef struct packed {
		logic [1:0]         op;
		logic               pressed;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic [TIME_W-1:0]  now_ms;
	} tgc_in_t;

	typedef struct packed {
		logic [2:0] gesture;
		logic       touch_active;
		logic       screen_awake;
	} tgc_out_t;

	typedef struct packed {
		logic [DEBOUNCE_W-1:0] debounce_ms;
		logic [THRESH_W-1:0]   swipe_min_px;
		logic [TAP_W-1:0]      tap_timeout_ms;
	} tgc_cfg_t;

	typedef struct packed {
		logic               in_touch;
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
		logic [TIME_W-1:0]  start_time;
		logic [TIME_W-1:0]  last_time;
		logic               swallow_next;
		logic               awake;
	} tgc_state_t;

endpackage

### hw/rtl/tgc_step.sv
// Next-state and result logic for one request against the touch state.
module tgc_step
	import tgc_pkg::*;
(
	input  tgc_in_t    item,
	input  tgc_state_t cur,
	input  tgc_cfg_t   cfg,
	output tgc_state_t nxt,
	output tgc_out_t   res
);

	logic signed [COORD_W:0] dx, dy;
	logic [COORD_W-1:0]      ax, ay;
	logic [TIME_W-1:0]       duration, since_contact;
	logic                    released;
	logic [2:0]              kind;
	logic [2:0]              g;

	always_comb begin
		dx = $signed({1'b0, cur.end_x}) - $signed({1'b0, cur.start_x});
		dy = $signed({1'b0, cur.end_y}) - $signed({1'b0, cur.start_y});
		// magnitude of an 11-bit difference of 10-bit values fits in 10 bits
		ax = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
		ay = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
		duration      = cur.last_time - cur.start_time;
		since_contact = item.now_ms - cur.last_time;
		released      = cur.in_touch && (since_contact > TIME_W'(cfg.debounce_ms));

		if (ax < cfg.swipe_min_px && ay < cfg.swipe_min_px) begin
			kind = (duration < TIME_W'(cfg.tap_timeout_ms)) ? G_TAP : G_HOLD;
		end else if (ax > ay) begin
			kind = (dx > 0) ? G_RIGHT : G_LEFT;
		end else begin
			kind = (dy > 0) ? G_DOWN : G_UP;
		end

		nxt = cur;
		g   = G_NONE;
		case (item.op)
			OP_WAKE: begin
				nxt.awake        = 1'b1;
				nxt.swallow_next = 1'b1;
			end
			OP_SLEEP: begin
				nxt.awake = 1'b0;
			end
			OP_POLL: begin
				if (item.pressed) begin
					nxt.last_time = item.now_ms;
					if (!cur.in_touch) begin
						nxt.start_x    = item.pos_x;
						nxt.start_y    = item.pos_y;
						nxt.start_time = item.now_ms;
						nxt.in_touch   = 1'b1;
					end
					nxt.end_x = item.pos_x;
					nxt.end_y = item.pos_y;
				end else if (released) begin
					nxt.in_touch = 1'b0;
					// drop the first gesture after a wake
					if (cur.swallow_next) begin
						nxt.swallow_next = 1'b0;
					end else begin
						g = kind;
					end
				end
			end
			default: begin
			end
		endcase

		res.gesture      = g;
		res.touch_active = nxt.in_touch;
		res.screen_awake = nxt.awake;
	end

endmodule

### hw/rtl/touch_gesture_classifier.sv
// Top level of the touch gesture classifier: request register, state and result register.
//
// Requests arrive on in_valid/in_ready with an in_data payload: a touch poll
// (pressed flag, x/y, millisecond timestamp), a wake event or a sleep event.
// Every request yields exactly one result on out_valid/out_ready: the gesture
// that finished with this request (or none), the touch-active flag and the
// awake flag after it.
// A request is registered in the request register on acceptance; the step logic then
// updates the touch state and loads the result register, raising out_valid, when the
// result register is empty or being read. One request per cycle is sustained while the
// receiver takes every result.
// When the receiver stalls, the result register holds and the request register
// keeps one more request; in_ready falls only when both are full.
// Configuration registers (debounce, swipe threshold, tap timeout) are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while the block
// is idle, which the block itself does not enforce. Unknown indexes are ignored.
// Reset clears the touch state, sets the awake flag, restores the configuration
// defaults (50 ms, 30 px, 300 ms) and empties both registers.
module touch_gesture_classifier
	import tgc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  tgc_in_t                in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output tgc_out_t               out_data,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	tgc_cfg_t   cfg_q;
	tgc_state_t st_q, st_nxt;
	tgc_in_t    item_s1;
	logic       valid_s1;
	tgc_out_t   res;
	logic       advance;

	assign advance  = !out_valid || out_ready;
	assign in_ready = !valid_s1 || advance;

	tgc_step u_step (
		.item (item_s1),
		.cur  (st_q),
		.cfg  (cfg_q),
		.nxt  (st_nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms    <= DEBOUNCE_RESET;
			cfg_q.swipe_min_px   <= THRESH_RESET;
			cfg_q.tap_timeout_ms <= TAP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEBOUNCE: cfg_q.debounce_ms    <= cfg_data[DEBOUNCE_W-1:0];
				CFG_THRESH:   cfg_q.swipe_min_px   <= cfg_data[THRESH_W-1:0];
				CFG_TAP:      cfg_q.tap_timeout_ms <= cfg_data[TAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= '{awake: 1'b1, default: '0};
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
			if (valid_s1) begin
				st_q <= st_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_data <= res;
		end
	end

	a_gesture_ends_touch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.gesture != G_NONE |-> !out_data.touch_active)
		else $error("gesture reported while touch still active");

	a_gesture_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.gesture != G_UNUSED)
		else $error("unused gesture code");

	a_touch_end_on_poll: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(st_q.in_touch) |-> $past(advance && valid_s1 && item_s1.op == OP_POLL
			&& !item_s1.pressed))
		else $error("touch ended without a release poll");

	a_wake_arms_swallow: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 && item_s1.op == OP_WAKE |=> st_q.swallow_next && st_q.awake
			&& out_valid && out_data.gesture == G_NONE)
		else $error("wake did not arm swallow");

endmodule
